// ===== design/byte_pipe_with_endpoint_counts_macros.svh =====
// Assertion macros for the byte pipe block.
// Used by design/byte_pipe_with_endpoint_counts.sv; needs i_clk and i_rst_n in scope.
`ifndef BYTE_PIPE_WITH_ENDPOINT_COUNTS_MACROS_SVH
`define BYTE_PIPE_WITH_ENDPOINT_COUNTS_MACROS_SVH

`ifndef ASSERT_OFF
`define BPEC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BPEC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define BPEC_ASSERT(lbl, prop, msg)
`define BPEC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/bpec_pkg.sv =====
// Shared types and constants for the byte pipe block.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package bpec_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam logic [1:0]  MODE_RD_ONLY = 2'd0;
    localparam logic [1:0]  MODE_WR_ONLY = 2'd1;
    localparam logic [7:0]  ENDS_MAX     = 8'hFF;
    localparam logic [15:0] PROGRESS_MAX = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_ADD   = 2'd2,
        CMD_CLOSE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BLOCK = 2'd1,
        ST_EOF   = 2'd2,
        ST_EPIPE = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd       command;
        logic [1:0] access_mode;
        logic [7:0] write_data;
        logic       request_last;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [7:0]  read_data;
        logic [12:0] fill_level;
        logic [15:0] request_bytes;
    } t_out_item;

endpackage

// ===== design/bpec_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bpec_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/byte_pipe_with_endpoint_counts.sv =====
// Top level of the byte pipe: ring control, endpoint counts, result register.
// Depends on bpec_pkg, bpec_ram and byte_pipe_with_endpoint_counts_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in) carries one byte access or
//   one endpoint event per transfer. Output channel (o_out_valid / i_out_ready
//   / o_out) returns exactly one result per input transfer, in order.
//   The result is registered and valid in the cycle after the input transfer.
//   Throughput: one transfer per cycle while the receiver takes results; the
//   limit is the single result register plus the ring RAM read port, whose
//   registered data feeds read_data directly.
//   A write goes to the ring RAM in the transfer cycle; a read addresses the
//   RAM in the transfer cycle, so a byte written one item earlier is seen.
//   Stall: while a result waits, o_in_ready is low; the result and the RAM
//   read data hold until the result transfers. o_in_ready is high again in
//   the cycle the receiver takes the result.
//   Reset (synchronous, active low): pointers, fill count and request progress
//   clear, reader and writer counts become one, no result is pending. The
//   ring contents are not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`include "byte_pipe_with_endpoint_counts_macros.svh"

module byte_pipe_with_endpoint_counts
    import bpec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out
);

    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_readers, n_readers;
    logic [7:0]       r_writers, n_writers;
    logic [15:0]      r_progress, n_progress;

    logic             r_out_valid;
    t_status          r_status, n_status;
    logic [CNT_W-1:0] r_fill;
    logic [15:0]      r_shown, n_shown;
    logic             r_rd_ok, n_rd_ok;

    logic             accept;
    logic             wr_en;
    logic             moved;
    logic             byte_item;
    logic             mode_rd, mode_wr;
    logic [7:0]       ram_rdata;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb begin
        n_rd_ptr   = r_rd_ptr;
        n_wr_ptr   = r_wr_ptr;
        n_count    = r_count;
        n_readers  = r_readers;
        n_writers  = r_writers;
        n_status   = ST_OK;
        n_rd_ok    = 1'b0;
        wr_en      = 1'b0;
        moved      = 1'b0;
        mode_rd    = (i_in.access_mode != MODE_WR_ONLY);
        mode_wr    = (i_in.access_mode != MODE_RD_ONLY);
        byte_item  = (i_in.command == CMD_WRITE) || (i_in.command == CMD_READ);

        unique case (i_in.command)
            CMD_WRITE: begin
                if (r_readers == 8'd0) begin
                    n_status = ST_EPIPE;
                end else if (r_count == CNT_W'(RING_DEPTH)) begin
                    n_status = ST_BLOCK;
                end else begin
                    wr_en    = 1'b1;
                    n_wr_ptr = next_slot(r_wr_ptr);
                    n_count  = r_count + CNT_W'(1);
                    moved    = 1'b1;
                end
            end
            CMD_READ: begin
                if (r_count != '0) begin
                    n_rd_ok  = 1'b1;
                    n_rd_ptr = next_slot(r_rd_ptr);
                    n_count  = r_count - CNT_W'(1);
                    moved    = 1'b1;
                end else if (r_writers == 8'd0) begin
                    n_status = ST_EOF;
                end else begin
                    n_status = ST_BLOCK;
                end
            end
            CMD_ADD: begin
                if (mode_rd && r_readers != ENDS_MAX) n_readers = r_readers + 8'd1;
                if (mode_wr && r_writers != ENDS_MAX) n_writers = r_writers + 8'd1;
            end
            CMD_CLOSE: begin
                if (mode_rd && r_readers != 8'd0) n_readers = r_readers - 8'd1;
                if (mode_wr && r_writers != 8'd0) n_writers = r_writers - 8'd1;
            end
        endcase

        n_shown = r_progress;
        if (moved && r_progress != PROGRESS_MAX) begin
            n_shown = r_progress + 16'd1;
        end
        n_progress = n_shown;
        if (byte_item && (n_status != ST_OK || i_in.request_last)) begin
            n_progress = '0;
        end
    end

    bpec_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (accept && wr_en),
        .i_waddr (r_wr_ptr),
        .i_wdata (i_in.write_data),
        .i_re    (accept && n_rd_ok),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr    <= '0;
            r_wr_ptr    <= '0;
            r_count     <= '0;
            r_readers   <= 8'd1;
            r_writers   <= 8'd1;
            r_progress  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_rd_ptr   <= n_rd_ptr;
                r_wr_ptr   <= n_wr_ptr;
                r_count    <= n_count;
                r_readers  <= n_readers;
                r_writers  <= n_writers;
                r_progress <= n_progress;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_fill   <= n_count;
            r_shown  <= n_shown;
            r_rd_ok  <= n_rd_ok;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.read_data     = r_rd_ok ? ram_rdata : 8'd0;
    assign o_out.fill_level    = 13'(r_fill);
    assign o_out.request_bytes = r_shown;

    `BPEC_ASSERT(a_count_bound, r_count <= CNT_W'(RING_DEPTH), "fill count beyond ring depth")
    `BPEC_ASSERT(a_stall_holds_ready, !o_in_ready |-> o_out_valid, "ready low without pending result")
    `BPEC_ASSERT(a_write_ok_fill, (accept && wr_en) |=> (r_count == $past(r_count) + CNT_W'(1)), "fill count did not rise on stored byte")
    `BPEC_ASSERT(a_epipe, (accept && i_in.command == CMD_WRITE && r_readers == 8'd0) |=> (o_out.status == ST_EPIPE), "write without readers not reported as broken pipe")
    `BPEC_ASSERT(a_read_ok_status, (o_out_valid && r_rd_ok) |-> (o_out.status == ST_OK), "read data shown with error status")
    `BPEC_ASSERT_ALWAYS(a_reset_clears, !$past(i_rst_n) |-> !o_out_valid, "result pending after reset")

endmodule
